### hw/rtl/pcksum_pkg.sv
// pcksum_pkg: word types, command/status structs and the CRC byte step
// shared by the cksum controller, datapath and top level. No dependencies.
package pcksum_pkg;

  localparam logic [31:0] CRC_GEN   = 32'h04C1_1DB7;
  localparam int          CRC_W     = 32;
  localparam int          COUNT_W   = 64;
  localparam int          BYTE_W    = 8;

  typedef enum logic {
    OP_DATA   = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    logic                op;
    logic [BYTE_W-1:0]   data_byte;
  } in_word_t;

  typedef struct packed {
    logic [CRC_W-1:0]    crc_value;
    logic [COUNT_W-1:0]  byte_count;
    logic                count_overflow;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic data_en;   // fold a stream byte, bump the count
    logic fin_load;  // copy the count into the length shifter
    logic len_step;  // fold the low length byte, shift right by one byte
    logic emit;      // load the result register, clear stream state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rest_zero; // no length bytes left to fold
  } stat_t;

  // Non-reflected CRC-32 update by one byte, MSB first.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_GEN;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/pcksum_dp.sv
// pcksum_dp: CRC register, byte counter, overflow flag, length shifter and
// result register. Depends on pcksum_pkg; driven by pcksum_ctrl commands.
module pcksum_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  pcksum_pkg::cmd_t       cmd,
  input  logic [7:0]             data_byte,
  output pcksum_pkg::stat_t      stat,
  output pcksum_pkg::out_word_t  result
);
  import pcksum_pkg::*;

  logic [CRC_W-1:0]   crc;
  logic [COUNT_W-1:0] count;
  logic               ovf;
  logic [COUNT_W-1:0] rest;
  out_word_t          res;

  assign stat.rest_zero = (rest == '0);
  assign result         = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.emit) begin
      crc   <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.data_en) begin
      crc   <= crc_byte(crc, data_byte);
      count <= count + COUNT_W'(1);
      if (count == '1) begin
        ovf <= 1'b1;  // wrapped to zero
      end
    end else if (cmd.len_step) begin
      crc <= crc_byte(crc, rest[BYTE_W-1:0]);
    end
  end

  // length shifter and result register: no reset needed
  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      rest <= count;
    end else if (cmd.len_step) begin
      rest <= {{BYTE_W{1'b0}}, rest[COUNT_W-1:BYTE_W]};
    end
    if (cmd.emit) begin
      res.crc_value      <= ~crc;
      res.byte_count     <= count;
      res.count_overflow <= ovf;
    end
  end

endmodule

### hw/rtl/pcksum_ctrl.sv
// pcksum_ctrl: handshake and sequencing for the cksum engine.
// Depends on pcksum_pkg; issues commands to pcksum_dp.
module pcksum_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pcksum_pkg::stat_t  stat,
  output pcksum_pkg::cmd_t   cmd
);
  import pcksum_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LEN
  } state_t;

  state_t state;
  logic   in_take;

  // finish waits until the result register is free
  assign in_stall = (state != S_IDLE) || ((in_op == OP_FINISH) && out_valid);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    cmd          = '0;
    cmd.data_en  = in_take && (in_op == OP_DATA);
    cmd.fin_load = in_take && (in_op == OP_FINISH);
    cmd.len_step = (state == S_LEN) && !stat.rest_zero;
    cmd.emit     = (state == S_LEN) && stat.rest_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.fin_load) begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          if (cmd.emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register must be empty when a checksum is loaded
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid)
    else $error("emit while result register occupied");

  // a loaded result is offered on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result not presented after emit");

  // a finish always leads into the length phase, never back-to-back input
  a_fin_len: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_load |=> (state == S_LEN) && in_stall)
    else $error("finish did not enter length phase");

  // only one kind of datapath update per cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.data_en, cmd.fin_load, cmd.len_step, cmd.emit}))
    else $error("conflicting datapath commands");

endmodule

### hw/rtl/posix_cksum_crc32_top.sv
// posix_cksum_crc32_top: POSIX cksum engine, top level.
// Depends on pcksum_pkg, pcksum_ctrl and pcksum_dp.
//
// Computes the POSIX cksum over a stream of data words. For a data word
// (op = 0) the byte is folded into a non-reflected CRC-32 (poly 0x04C11DB7,
// init 0, MSB first) and the 64-bit byte count advances, so data streams at
// one word per clock except while a finish is in its length phase. A finish
// word (op = 1) copies the count into a length shifter, whose 0..8
// significant bytes are folded into the CRC low byte first, one byte per
// clock through the crc_byte step, and the inverted CRC, the count and a
// sticky overflow flag are loaded into the result register. Stream state is
// cleared at that point, so the next stream may begin while the result still
// waits on the output. A finish word is held off while an earlier result is
// still waiting. If the count wraps past 64 bits the overflow flag is set and
// the wrapped count is used. data_byte is ignored on finish.
module posix_cksum_crc32_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pcksum_pkg::in_word_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pcksum_pkg::out_word_t  out_data
);
  import pcksum_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: handshakes and length phase
  pcksum_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // CRC, count and result storage
  pcksum_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (in_data.data_byte),
    .stat      (stat),
    .result    (out_data)
  );

endmodule
